>>> hdl/efhp_pkg.sv
// ----------------------------------------------------------------------------
// efhp_pkg
// Shared types and constants of the earliest-finish host picker.
// ----------------------------------------------------------------------------
package efhp_pkg;

	localparam int MAX_HOSTS = 64;
	localparam int HOST_W    = $clog2(MAX_HOSTS);
	localparam int CNT_W     = HOST_W + 1;
	localparam int TIME_W    = 48;
	localparam int DUR_W     = 32;
	localparam int SLOT_W    = 8;
	localparam int STAT_W    = 2;

	// divider: DIV_STEPS quotient bits per stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = DUR_W / DIV_STEPS;

	localparam logic [STAT_W-1:0] STATUS_PLACED   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_HOSTS = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_STORED   = 2'd2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic              mode;
		logic [HOST_W-1:0] host_number;
		logic [SLOT_W-1:0] slot_count;
		logic [DUR_W-1:0]  job_duration;
		logic [TIME_W-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [HOST_W-1:0] chosen_host;
		logic [TIME_W-1:0] finish_time;
	} rsp_t;

	// travels with each host through the scan pipeline
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [HOST_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic              en;
		logic [HOST_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} slot_wr_t;

	typedef struct packed {
		logic              en;
		logic [HOST_W-1:0] addr;
		logic [TIME_W-1:0] data;
	} fin_wr_t;

	typedef struct packed {
		logic              done;
		logic [HOST_W-1:0] idx;
		logic [TIME_W-1:0] ftime;
	} pick_t;

endpackage

>>> hdl/efhp_host_table.sv
// ----------------------------------------------------------------------------
// efhp_host_table
// Busy-until and slot-count memories, one read port each (shared address),
// registered read data. Per-entry valid bits give the all-zero reset.
// ----------------------------------------------------------------------------
module efhp_host_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efhp_pkg::tag_t               rd_tag,
	input  efhp_pkg::slot_wr_t           slot_wr,
	input  efhp_pkg::fin_wr_t            fin_wr,
	output efhp_pkg::tag_t               tag_s1,
	output logic [efhp_pkg::TIME_W-1:0]  busy_s1,
	output logic [efhp_pkg::SLOT_W-1:0]  slots_s1
);

	logic [efhp_pkg::TIME_W-1:0] fin_mem  [efhp_pkg::MAX_HOSTS];
	logic [efhp_pkg::SLOT_W-1:0] slot_mem [efhp_pkg::MAX_HOSTS];
	logic [efhp_pkg::MAX_HOSTS-1:0] fin_vld_q;
	logic [efhp_pkg::MAX_HOSTS-1:0] slot_vld_q;

	logic [efhp_pkg::TIME_W-1:0] fin_rd_s1;
	logic [efhp_pkg::SLOT_W-1:0] slot_rd_s1;
	logic                        fin_ok_s1;
	logic                        slot_ok_s1;

	always_ff @(posedge clk) begin
		if (fin_wr.en) begin
			fin_mem[fin_wr.addr] <= fin_wr.data;
		end
		if (slot_wr.en) begin
			slot_mem[slot_wr.addr] <= slot_wr.data;
		end
		fin_rd_s1  <= fin_mem[rd_tag.idx];
		slot_rd_s1 <= slot_mem[rd_tag.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q  <= '0;
			slot_vld_q <= '0;
			tag_s1     <= '0;
			fin_ok_s1  <= 1'b0;
			slot_ok_s1 <= 1'b0;
		end else begin
			if (fin_wr.en) begin
				fin_vld_q[fin_wr.addr] <= 1'b1;
			end
			if (slot_wr.en) begin
				slot_vld_q[slot_wr.addr] <= 1'b1;
			end
			tag_s1     <= rd_tag;
			fin_ok_s1  <= fin_vld_q[rd_tag.idx];
			slot_ok_s1 <= slot_vld_q[rd_tag.idx];
		end
	end

	assign busy_s1  = fin_ok_s1  ? fin_rd_s1  : '0;
	assign slots_s1 = slot_ok_s1 ? slot_rd_s1 : '0;

endmodule

>>> hdl/efhp_div_pipe.sv
// ----------------------------------------------------------------------------
// efhp_div_pipe
// Start time max(busy, now) and a pipelined restoring divider
// job_duration / slots, DIV_STEPS quotient bits per stage, one host per cycle.
// ----------------------------------------------------------------------------
module efhp_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efhp_pkg::tag_t               tag_in,
	input  logic [efhp_pkg::TIME_W-1:0]  busy,
	input  logic [efhp_pkg::SLOT_W-1:0]  slots,
	input  logic [efhp_pkg::DUR_W-1:0]   dur,
	input  logic [efhp_pkg::TIME_W-1:0]  now,
	output efhp_pkg::tag_t               tag_out,
	output logic [efhp_pkg::TIME_W-1:0]  start,
	output logic [efhp_pkg::DUR_W-1:0]   quo
);

	typedef struct packed {
		efhp_pkg::tag_t              tag;
		logic [efhp_pkg::TIME_W-1:0] start;
		logic [efhp_pkg::SLOT_W-1:0] divisor;
		logic [efhp_pkg::SLOT_W-1:0] rem;
		logic [efhp_pkg::DUR_W-1:0]  nq;   // numerator shifts out, quotient shifts in
	} div_t;

	function automatic div_t div_step(div_t d);
		div_t                      r;
		logic [efhp_pkg::SLOT_W:0] part;
		r = d;
		for (int k = 0; k < efhp_pkg::DIV_STEPS; k++) begin
			part = {r.rem, r.nq[efhp_pkg::DUR_W-1]};
			r.nq = {r.nq[efhp_pkg::DUR_W-2:0], 1'b0};
			if (part >= {1'b0, r.divisor}) begin
				part    = part - {1'b0, r.divisor};
				r.nq[0] = 1'b1;
			end
			r.rem = part[efhp_pkg::SLOT_W-1:0];
		end
		return r;
	endfunction

	div_t stg_s [efhp_pkg::DIV_STAGES+1];
	div_t head;

	always_comb begin
		head         = '0;
		head.tag     = tag_in;
		head.start   = (busy > now) ? busy : now;
		head.divisor = (slots == '0) ? efhp_pkg::SLOT_W'(1) : slots;
		head.rem     = '0;
		head.nq      = dur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= efhp_pkg::DIV_STAGES; s++) begin
				stg_s[s] <= '0;
			end
		end else begin
			stg_s[0] <= head;
			for (int s = 0; s < efhp_pkg::DIV_STAGES; s++) begin
				stg_s[s+1] <= div_step(stg_s[s]);
			end
		end
	end

	assign tag_out = stg_s[efhp_pkg::DIV_STAGES].tag;
	assign start   = stg_s[efhp_pkg::DIV_STAGES].start;
	assign quo     = stg_s[efhp_pkg::DIV_STAGES].nq;

endmodule

>>> hdl/efhp_best_pick.sv
// ----------------------------------------------------------------------------
// efhp_best_pick
// Saturating finish-time add, then running minimum over the scan.
// Lowest index wins ties; the scan always starts at host 0.
// ----------------------------------------------------------------------------
module efhp_best_pick (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efhp_pkg::tag_t               tag_in,
	input  logic [efhp_pkg::TIME_W-1:0]  start,
	input  logic [efhp_pkg::DUR_W-1:0]   quo,
	output efhp_pkg::pick_t              pick
);

	logic [efhp_pkg::TIME_W:0]   sum;
	efhp_pkg::tag_t              tag_s1;
	logic [efhp_pkg::TIME_W-1:0] ftime_s1;
	logic [efhp_pkg::HOST_W-1:0] best_idx_q;
	logic [efhp_pkg::TIME_W-1:0] best_time_q;
	logic                        done_q;

	assign sum = {1'b0, start} + (efhp_pkg::TIME_W+1)'(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag_in;
			done_q <= tag_s1.vld && tag_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		ftime_s1 <= sum[efhp_pkg::TIME_W] ? efhp_pkg::TIME_MAX : sum[efhp_pkg::TIME_W-1:0];
		if (tag_s1.vld && (tag_s1.idx == '0 || ftime_s1 < best_time_q)) begin
			best_idx_q  <= tag_s1.idx;
			best_time_q <= ftime_s1;
		end
	end

	assign pick.done  = done_q;
	assign pick.idx   = best_idx_q;
	assign pick.ftime = best_time_q;

endmodule

>>> hdl/earliest_finish_host_picker.sv
// ----------------------------------------------------------------------------
// earliest_finish_host_picker
// Picks the host with the earliest finish time for a job and books it.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_data): a word with mode 0
// stores a host's slot count; mode 1 schedules one job. Every request word
// gives exactly one response word on rsp_valid / rsp_stall / rsp_data.
// Configuration: cfg_valid / cfg_ready / cfg_data write active_hosts; write
// it only while the block is idle. cfg_ready is always high.
// Flow: a mode-0 word or a mode-1 word with no active hosts goes straight
// to the response state. A mode-1 word scans N = min(active_hosts, 64)
// hosts: the host table has one read port and delivers one host per cycle
// into a pipelined divider and a running minimum.
// One request is in work at a time; req_stall is high until its response
// sits in the output register. The next request is taken while that
// response still waits for the receiver, and a stalled response holds.
// Reset (arst_n low) clears the busy-until times, slot counts and
// active_hosts to zero and empties the output register.
// ----------------------------------------------------------------------------
module earliest_finish_host_picker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  efhp_pkg::req_t                req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output efhp_pkg::rsp_t                rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [efhp_pkg::CNT_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;

	logic [2:0]                  state_q;
	logic [efhp_pkg::CNT_W-1:0]  active_hosts_q;
	logic [efhp_pkg::CNT_W-1:0]  cnt;
	logic [efhp_pkg::CNT_W-1:0]  cnt_m1;
	logic [efhp_pkg::HOST_W-1:0] scan_idx_q;
	logic [efhp_pkg::HOST_W-1:0] last_idx_q;
	logic [efhp_pkg::DUR_W-1:0]  dur_q;
	logic [efhp_pkg::TIME_W-1:0] now_q;
	efhp_pkg::rsp_t              res_q;
	efhp_pkg::rsp_t              rsp_q;
	logic                        rsp_vld_q;
	logic                        req_accept;
	logic                        out_free;
	logic                        out_load;

	efhp_pkg::tag_t              rd_tag;
	efhp_pkg::slot_wr_t          slot_wr;
	efhp_pkg::fin_wr_t           fin_wr;
	efhp_pkg::tag_t              tbl_tag_s1;
	logic [efhp_pkg::TIME_W-1:0] busy_s1;
	logic [efhp_pkg::SLOT_W-1:0] slots_s1;
	efhp_pkg::tag_t              div_tag;
	logic [efhp_pkg::TIME_W-1:0] div_start;
	logic [efhp_pkg::DUR_W-1:0]  div_quo;
	efhp_pkg::pick_t             pick;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_hosts_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_hosts_q <= cfg_data;
		end
	end

	assign cnt = (active_hosts_q > efhp_pkg::CNT_W'(efhp_pkg::MAX_HOSTS))
		? efhp_pkg::CNT_W'(efhp_pkg::MAX_HOSTS) : active_hosts_q;
	assign cnt_m1 = cnt - efhp_pkg::CNT_W'(1);

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_vld_q || !rsp_stall;
	assign out_load   = (state_q == ST_POST) && out_free;

	// slot count goes in at the accept edge; no scan reads are in flight then
	assign slot_wr.en   = req_accept && !req_data.mode;
	assign slot_wr.addr = req_data.host_number;
	assign slot_wr.data = req_data.slot_count;

	// booking of the winner; the scan of this job has fully drained
	assign fin_wr.en   = (state_q == ST_DRAIN) && pick.done;
	assign fin_wr.addr = pick.idx;
	assign fin_wr.data = pick.ftime;

	assign rd_tag.vld  = (state_q == ST_SCAN);
	assign rd_tag.last = (scan_idx_q == last_idx_q);
	assign rd_tag.idx  = scan_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						if (req_data.mode && cnt != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_POST;
						end
					end
				end
				ST_SCAN: begin
					if (rd_tag.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pick.done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_accept) begin
			dur_q      <= req_data.job_duration;
			now_q      <= req_data.now_time;
			last_idx_q <= cnt_m1[efhp_pkg::HOST_W-1:0];
			scan_idx_q <= '0;
			res_q.chosen_host <= '0;
			res_q.finish_time <= '0;
			res_q.status      <= req_data.mode ? efhp_pkg::STATUS_NO_HOSTS
				: efhp_pkg::STATUS_STORED;
		end else if (state_q == ST_SCAN) begin
			scan_idx_q <= scan_idx_q + efhp_pkg::HOST_W'(1);
		end else if (fin_wr.en) begin
			res_q.status      <= efhp_pkg::STATUS_PLACED;
			res_q.chosen_host <= pick.idx;
			res_q.finish_time <= pick.ftime;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_vld_q && !rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	efhp_host_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_tag   (rd_tag),
		.slot_wr  (slot_wr),
		.fin_wr   (fin_wr),
		.tag_s1   (tbl_tag_s1),
		.busy_s1  (busy_s1),
		.slots_s1 (slots_s1)
	);

	efhp_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tbl_tag_s1),
		.busy    (busy_s1),
		.slots   (slots_s1),
		.dur     (dur_q),
		.now     (now_q),
		.tag_out (div_tag),
		.start   (div_start),
		.quo     (div_quo)
	);

	efhp_best_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_in (div_tag),
		.start  (div_start),
		.quo    (div_quo),
		.pick   (pick)
	);

	// a pick result appears only while the job waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		pick.done |-> state_q == ST_DRAIN)
		else $error("pick result outside drain");

	// a finish time never lies before the request's current time
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && pick.done) |-> pick.ftime >= now_q)
		else $error("finish time before now");

	// slot count stores answer without a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && !req_data.mode) |=> state_q == ST_POST)
		else $error("slot store did not go to response");

	// a new response is loaded only from the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q) == ST_POST)
		else $error("response loaded outside response state");

endmodule

>>> verif/tb_earliest_finish_host_picker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_earliest_finish_host_picker
// Self-checking bench for the earliest-finish host picker.
// A directed table first covers an empty host set, zero and full slot counts,
// ties, saturation at the top of the time range and a host count above the
// table size. Random traffic follows, about a third slot stores and the rest
// jobs, mostly on an advancing clock, with both channels idling in several
// mixes. Every response word is compared with a local model of the host table.
// ----------------------------------------------------------------------------
module tb_earliest_finish_host_picker;
	import efhp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 100;
	localparam int MAX_SHOWN      = 10;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 119;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

	typedef struct {
		row_kind_e         kind;
		logic [CNT_W-1:0]  hosts;
		req_t              word;
		bit                typed;
		rsp_t              want;
	} dir_row_t;

	typedef struct {
		bit   typed;
		rsp_t want;
	} answer_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req_data  = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	// model of the host table
	logic [TIME_W-1:0] busy_until [MAX_HOSTS] = '{default: '0};
	logic [SLOT_W-1:0] slots_of   [MAX_HOSTS] = '{default: '0};
	logic [CNT_W-1:0]  hosts_on = '0;

	rsp_t     due_rsps[$];
	answer_t  table_answers[$];
	dir_row_t dir_rows[$];

	int fail_count    = 0;
	int shown         = 0;
	int idle_cycles   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;

	earliest_finish_host_picker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Applies one request word to the model and returns the response it owes.
	function automatic rsp_t book_word(input req_t w);
		rsp_t              r;
		int                n;
		int                pick;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] add;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] best;
		logic [TIME_W:0]   sum;
		logic [SLOT_W-1:0] div;
		r = '0;
		if (w.mode == 1'b0) begin
			slots_of[w.host_number] = w.slot_count;
			r.status = STATUS_STORED;
			return r;
		end
		n = (hosts_on > MAX_HOSTS) ? MAX_HOSTS : int'(hosts_on);
		if (n == 0) begin
			r.status = STATUS_NO_HOSTS;
			return r;
		end
		best = '0;
		pick = 0;
		for (int i = 0; i < n; i++) begin
			start = (busy_until[i] > w.now_time) ? busy_until[i] : w.now_time;
			div   = (slots_of[i] == '0) ? 8'd1 : slots_of[i];
			add   = TIME_W'(w.job_duration / div);
			sum   = {1'b0, start} + {1'b0, add};
			t     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			// strict compare keeps the lowest index on a tie
			if (i == 0 || t < best) begin
				best = t;
				pick = i;
			end
		end
		busy_until[pick] = best;
		r.status      = STATUS_PLACED;
		r.chosen_host = pick[HOST_W-1:0];
		r.finish_time = best;
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// prediction, response check and watchdog
	always @(posedge clk) begin
		answer_t a;
		rsp_t    want;
		rsp_t    got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				hosts_on = cfg_data;
			if (req_valid && !req_stall) begin
				want = book_word(req_data);
				if (table_answers.size() != 0) begin
					a = table_answers.pop_front();
					if (a.typed)
						want = a.want;
				end
				due_rsps.push_back(want);
			end
			if (rsp_valid && !rsp_stall) begin
				got = rsp_data;
				if (due_rsps.size() == 0) begin
					fail_count++;
					if (shown < MAX_SHOWN) begin
						shown++;
						$display("unexpected response word: status %0d host %0d finish %0d",
							got.status, got.chosen_host, got.finish_time);
					end
				end else begin
					want = due_rsps.pop_front();
					if (got.status !== want.status || got.chosen_host !== want.chosen_host ||
						got.finish_time !== want.finish_time) begin
						fail_count++;
						if (shown < MAX_SHOWN) begin
							shown++;
							$display("mismatch (exp/act): status %0d/%0d host %0d/%0d finish %0d/%0d",
								want.status, got.status, want.chosen_host, got.chosen_host,
								want.finish_time, got.finish_time);
						end
					end
				end
			end
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(input req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= w;
		do @(posedge clk); while (req_stall);
	endtask

	// waits until every word sent so far has been answered
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic write_hosts(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_cfg(input logic [CNT_W-1:0] v);
		dir_row_t r;
		r.kind  = ROW_CFG;
		r.hosts = v;
		r.word  = '0;
		r.typed = 1'b0;
		r.want  = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_req(input logic m, input logic [HOST_W-1:0] h,
		input logic [SLOT_W-1:0] s, input logic [DUR_W-1:0] d, input logic [TIME_W-1:0] t,
		input bit typed, input logic [STAT_W-1:0] st, input logic [HOST_W-1:0] ch,
		input logic [TIME_W-1:0] ft);
		dir_row_t r;
		r.kind               = ROW_REQ;
		r.hosts              = '0;
		r.word.mode          = m;
		r.word.host_number   = h;
		r.word.slot_count    = s;
		r.word.job_duration  = d;
		r.word.now_time      = t;
		r.typed              = typed;
		r.want.status        = st;
		r.want.chosen_host   = ch;
		r.want.finish_time   = ft;
		dir_rows.push_back(r);
	endtask

	initial begin
		answer_t           a;
		req_t              w;
		logic [63:0]       r64;
		logic [TIME_W-1:0] wall_clock;
		logic [CNT_W-1:0]  phase_hosts [PHASES];
		int                n_on;
		int                sel;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no host active after reset
		add_req(1'b1, 6'd0, 8'd0, 32'd100, 48'd50, 1'b1, STATUS_NO_HOSTS, 6'd0, 48'd0);
		add_req(1'b0, 6'd0, 8'd0, 32'd0, 48'd0, 1'b1, STATUS_STORED, 6'd0, 48'd0);
		add_req(1'b0, 6'd63, 8'd255, 32'hFFFF_FFFF, TIME_MAX, 1'b1, STATUS_STORED, 6'd0,
			48'd0);
		add_req(1'b0, 6'd1, 8'd1, 32'd0, 48'd0, 1'b1, STATUS_STORED, 6'd0, 48'd0);
		add_req(1'b0, 6'd2, 8'd7, 32'd0, 48'd0, 1'b1, STATUS_STORED, 6'd0, 48'd0);
		add_cfg(7'd64);
		add_req(1'b1, 6'd0, 8'd0, 32'd0, 48'd0, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		add_req(1'b1, 6'd63, 8'd255, 32'hFFFF_FFFF, 48'd0, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		add_req(1'b1, 6'd0, 8'd0, 32'd1000, 48'd5, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		// start at the top of the range: all saturate, host 0 wins the tie
		add_req(1'b1, 6'd0, 8'd0, 32'hFFFF_FFFF, TIME_MAX, 1'b1, STATUS_PLACED, 6'd0,
			TIME_MAX);
		add_req(1'b1, 6'd0, 8'd0, 32'd1000, TIME_MAX - 48'd500, 1'b0, STATUS_PLACED, 6'd0,
			48'd0);
		// count above the table acts as a full table
		add_cfg(7'd127);
		add_req(1'b1, 6'd0, 8'd0, 32'd12345, 48'd100, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		add_req(1'b0, 6'd5, 8'd3, 32'd0, 48'd0, 1'b1, STATUS_STORED, 6'd0, 48'd0);
		add_req(1'b1, 6'd0, 8'd0, 32'd999, 48'd7, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		// host 0 is booked to the end of time
		add_cfg(7'd1);
		add_req(1'b1, 6'd0, 8'd0, 32'd50, 48'd10, 1'b1, STATUS_PLACED, 6'd0, TIME_MAX);
		add_cfg(7'd0);
		add_req(1'b1, 6'd63, 8'd255, 32'hFFFF_FFFF, TIME_MAX, 1'b1, STATUS_NO_HOSTS, 6'd0,
			48'd0);
		add_cfg(7'd2);
		add_req(1'b1, 6'd0, 8'd0, 32'd9, 48'd1, 1'b0, STATUS_PLACED, 6'd0, 48'd0);
		add_req(1'b1, 6'd0, 8'd0, 32'd9, 48'd1, 1'b0, STATUS_PLACED, 6'd0, 48'd0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_hosts(dir_rows[i].hosts);
			end else begin
				a.typed = dir_rows[i].typed;
				a.want  = dir_rows[i].want;
				table_answers.push_back(a);
				send_word(dir_rows[i].word);
			end
		end

		phase_hosts = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd64, 7'd17, 7'd64};
		phase_hosts[6] = CNT_W'($urandom_range(2, 63));
		wall_clock = '0;

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_hosts(phase_hosts[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 87; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 87; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			n_on = (phase_hosts[p] > MAX_HOSTS) ? MAX_HOSTS : int'(phase_hosts[p]);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				w.mode = ($urandom_range(99) < 35) ? 1'b0 : 1'b1;
				// slot stores mostly land on hosts that take part
				if (n_on > 0 && $urandom_range(1) == 0)
					w.host_number = HOST_W'($urandom_range(n_on - 1));
				else
					w.host_number = HOST_W'($urandom_range(63));
				sel = $urandom_range(3);
				if (sel == 0)
					w.slot_count = 8'd0;
				else if (sel == 1)
					w.slot_count = SLOT_W'($urandom_range(1, 8));
				else
					w.slot_count = SLOT_W'($urandom_range(255));
				sel = $urandom_range(9);
				if (sel == 0)
					w.job_duration = 32'd0;
				else if (sel == 1)
					w.job_duration = 32'hFFFF_FFFF;
				else if (sel <= 3)
					w.job_duration = $urandom;
				else
					w.job_duration = $urandom_range(1, 100000);
				sel = $urandom_range(39);
				if (sel == 0) begin
					w.now_time = TIME_MAX - 48'($urandom_range(1000));
				end else if (sel == 1) begin
					r64 = {$urandom, $urandom};
					w.now_time = r64[TIME_W-1:0];
				end else begin
					wall_clock = wall_clock + 48'($urandom_range(20000));
					w.now_time = wall_clock;
				end
				send_word(w);
			end
		end

		drain();
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hdl/efhp_pkg.sv
hdl/efhp_host_table.sv
hdl/efhp_div_pipe.sv
hdl/efhp_best_pick.sv
hdl/earliest_finish_host_picker.sv
verif/tb_earliest_finish_host_picker.sv
